// File: rtl/assert_macros.svh
// Assertion macros shared by the RTL of the address range region table.
// Depends on nothing; define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)

`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

// File: rtl/arrt_pkg.sv
// Types and codes for the address range region table.
// Depends on nothing; used by the top level.
package arrt_pkg;

    localparam int unsigned ADDR_W   = 64;
    localparam int unsigned SLOT_W   = 4;
    localparam int unsigned STATUS_W = 3;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_ZERO     = 3'd2,
        ST_OVERFLOW = 3'd3,
        ST_OVERLAP  = 3'd4,
        ST_NOMATCH  = 3'd5
    } status_t;

    typedef enum logic {
        OP_REGISTER = 1'b0,
        OP_LOOKUP   = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PREP,
        S_SCAN,
        S_DONE
    } state_t;

endpackage

// File: rtl/arrt_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
module arrt_ram #(
    parameter int unsigned WIDTH = 128,
    parameter int unsigned DEPTH = 16
) (
    input  logic                                       aclk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic                                       re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/address_range_region_table.sv
// Top level of the address range region table: sequencer, shared range compare, result register.
// Depends on arrt_pkg, arrt_ram and assert_macros.svh.
//
//   channel | ports                                        | handshake
//   request | s_op s_region_base s_region_size s_fault_... | s_valid / s_ready
//   result  | m_status m_slot m_offset                     | m_valid / m_ready
//
// A request scans the stored regions until a hit or the table end, read one per cycle
// from the region memory into one compare unit. Register requests that fail the full,
// zero size or overflow checks skip the scan. A new request is taken while the last result
// still waits; the sequencer then holds its result until the output register is free.
// Reset clears the state, the region count and the valid and write-pending flags.
`include "assert_macros.svh"

module address_range_region_table #(
    parameter int unsigned ENTRIES = 16
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic                             s_op,
    input  logic [arrt_pkg::ADDR_W-1:0]      s_region_base,
    input  logic [arrt_pkg::ADDR_W-1:0]      s_region_size,
    input  logic [arrt_pkg::ADDR_W-1:0]      s_fault_address,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [arrt_pkg::STATUS_W-1:0]    m_status,
    output logic [arrt_pkg::SLOT_W-1:0]      m_slot,
    output logic [arrt_pkg::ADDR_W-1:0]      m_offset
);

    import arrt_pkg::*;

    localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int unsigned CNT_W = $clog2(ENTRIES + 1);

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   scan_idx_reg, scan_idx_next;
    logic               cmp_vld_reg, cmp_vld_next;
    logic [IDX_W-1:0]   cmp_idx_reg, cmp_idx_next;
    op_t                op_reg, op_next;
    logic [ADDR_W-1:0]  base_reg, base_next;
    logic [ADDR_W-1:0]  size_reg, size_next;
    logic [ADDR_W-1:0]  key_lo_reg, key_lo_next;
    logic [ADDR_W-1:0]  key_hi_reg, key_hi_next;
    status_t            res_status_reg, res_status_next;
    logic [SLOT_W-1:0]  res_slot_reg, res_slot_next;
    logic [ADDR_W-1:0]  res_offset_reg, res_offset_next;
    logic               wr_pend_reg, wr_pend_next;
    logic               m_valid_reg, m_valid_next;
    status_t            m_status_reg, m_status_next;
    logic [SLOT_W-1:0]  m_slot_reg, m_slot_next;
    logic [ADDR_W-1:0]  m_offset_reg, m_offset_next;

    logic                  ram_we;
    logic                  ram_re;
    logic [2*ADDR_W-1:0]   ram_rdata;
    logic [ADDR_W-1:0]     ent_start;
    logic [ADDR_W-1:0]     ent_end;
    logic [ADDR_W:0]       end_sum;
    logic                  lo_ok;
    logic                  hi_ge;
    logic                  hi_ok;
    logic                  hit;
    logic                  out_free;

    arrt_ram #(
        .WIDTH (2 * ADDR_W),
        .DEPTH (ENTRIES)
    ) u_region_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (count_reg[IDX_W-1:0]),
        .wdata ({base_reg, key_hi_reg}),
        .re    (ram_re),
        .raddr (scan_idx_reg[IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    // Shared range compare: a stored region [start, end) meets the key when
    // key_lo < end and key_hi reaches start (strictly beyond it for a new region's end).
    assign ent_start = ram_rdata[2*ADDR_W-1:ADDR_W];
    assign ent_end   = ram_rdata[ADDR_W-1:0];
    assign lo_ok     = key_lo_reg < ent_end;
    assign hi_ge     = key_hi_reg >= ent_start;
    assign hi_ok     = (op_reg == OP_LOOKUP) ? hi_ge : (hi_ge && (key_hi_reg != ent_start));
    assign hit       = cmp_vld_reg && lo_ok && hi_ok;
    assign end_sum   = {1'b0, base_reg} + {1'b0, size_reg};
    assign out_free  = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            cmp_vld_reg <= 1'b0;
            wr_pend_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            cmp_vld_reg <= cmp_vld_next;
            wr_pend_reg <= wr_pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        scan_idx_reg   <= scan_idx_next;
        cmp_idx_reg    <= cmp_idx_next;
        op_reg         <= op_next;
        base_reg       <= base_next;
        size_reg       <= size_next;
        key_lo_reg     <= key_lo_next;
        key_hi_reg     <= key_hi_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        res_offset_reg <= res_offset_next;
        m_status_reg   <= m_status_next;
        m_slot_reg     <= m_slot_next;
        m_offset_reg   <= m_offset_next;
    end

    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        scan_idx_next   = scan_idx_reg;
        cmp_vld_next    = 1'b0;
        cmp_idx_next    = cmp_idx_reg;
        op_next         = op_reg;
        base_next       = base_reg;
        size_next       = size_reg;
        key_lo_next     = key_lo_reg;
        key_hi_next     = key_hi_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        res_offset_next = res_offset_reg;
        wr_pend_next    = wr_pend_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_status_next   = m_status_reg;
        m_slot_next     = m_slot_reg;
        m_offset_next   = m_offset_reg;
        s_ready         = 1'b0;
        ram_we          = 1'b0;
        ram_re          = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    op_next      = op_t'(s_op);
                    base_next    = s_region_base;
                    size_next    = s_region_size;
                    key_lo_next  = s_op ? s_fault_address : s_region_base;
                    key_hi_next  = s_fault_address;
                    wr_pend_next = 1'b0;
                    state_next   = S_PREP;
                end
            end
            S_PREP: begin
                scan_idx_next   = '0;
                res_slot_next   = '0;
                res_offset_next = '0;
                state_next      = S_DONE;
                if (op_reg == OP_LOOKUP) begin
                    state_next = S_SCAN;
                end else begin
                    key_hi_next = end_sum[ADDR_W-1:0];
                    priority if (count_reg == CNT_W'(ENTRIES)) begin
                        res_status_next = ST_FULL;
                    end else if (size_reg == '0) begin
                        res_status_next = ST_ZERO;
                    end else if (end_sum[ADDR_W]) begin
                        res_status_next = ST_OVERFLOW;
                    end else begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                ram_re = scan_idx_reg < count_reg;
                if (hit) begin
                    state_next = S_DONE;
                    if (op_reg == OP_LOOKUP) begin
                        res_status_next = ST_OK;
                        res_slot_next   = SLOT_W'(cmp_idx_reg);
                        res_offset_next = key_lo_reg - ent_start;
                    end else begin
                        res_status_next = ST_OVERLAP;
                    end
                end else if (!ram_re && !cmp_vld_reg) begin
                    state_next = S_DONE;
                    if (op_reg == OP_LOOKUP) begin
                        res_status_next = ST_NOMATCH;
                    end else begin
                        res_status_next = ST_OK;
                        res_slot_next   = SLOT_W'(count_reg);
                        wr_pend_next    = 1'b1;
                    end
                end else begin
                    cmp_vld_next = ram_re;
                    cmp_idx_next = scan_idx_reg[IDX_W-1:0];
                    if (ram_re) begin
                        scan_idx_next = scan_idx_reg + 1'b1;
                    end
                end
            end
            S_DONE: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_slot_next   = res_slot_reg;
                    m_offset_next = res_offset_reg;
                    state_next    = S_IDLE;
                    if (wr_pend_reg) begin
                        ram_we       = 1'b1;
                        count_next   = count_reg + 1'b1;
                        wr_pend_next = 1'b0;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign m_valid  = m_valid_reg;
    assign m_status = m_status_reg;
    assign m_slot   = m_slot_reg;
    assign m_offset = m_offset_reg;

    `ASSERT_CLK(a_count_bound, aclk, aresetn, count_reg <= CNT_W'(ENTRIES), "region count exceeds table size")
    `ASSERT_CLK(a_count_step, aclk, aresetn, (count_reg != $past(count_reg)) |-> (count_reg == $past(count_reg) + 1'b1), "region count moved by more than one")
    `ASSERT_CLK(a_write_room, aclk, aresetn, ram_we |-> (count_reg < CNT_W'(ENTRIES)), "region written into a full table")
    `ASSERT_CLK(a_cmp_in_range, aclk, aresetn, (state_reg == S_SCAN && cmp_vld_reg) |-> (CNT_W'(cmp_idx_reg) < count_reg), "compare on an unwritten slot")
    `ASSERT_CLK(a_write_ok, aclk, aresetn, ram_we |-> (res_status_reg == ST_OK && op_reg == OP_REGISTER), "region stored without an ok status")

endmodule
